[src/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising clock edge, held off while reset is low.
`define ASSERT_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Concurrent assertion on the rising clock edge that also covers reset cycles.
`define ASSERT_ANY(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

[src/pic_pkg.sv]
package pic_pkg;

    // Field widths
    localparam int COORD_W = 24;
    localparam int COUNT_W = 20;
    localparam int RAD_W   = 16;

    // Derived arithmetic widths (all signed unless noted)
    localparam int DW    = COORD_W + 1;      // coordinate difference
    localparam int CW    = 2 * DW + 1;       // cross product component
    localparam int L2W   = 2 * DW + 1;       // squared length, dot product
    localparam int AW    = CW;               // multiplier A operand
    localparam int XW    = 4 * DW;           // squared cross norm, unsigned
    localparam int RRW   = 2 * RAD_W;        // radius squared, unsigned
    localparam int RLW   = 2 * DW + RRW;     // radius^2 * length^2, unsigned
    localparam int ACC_W = ((XW > RLW) ? XW : RLW) + 4;

    // Digit-serial multiplier: B operand consumed 16 bits per pass
    localparam int DIG_W  = 16;
    localparam int DIG_LG = $clog2(DIG_W);
    localparam int ND_D   = (DW + DIG_W - 1) / DIG_W;
    localparam int ND_C   = (CW + DIG_W - 1) / DIG_W;
    localparam int ND_RAD = (RAD_W + DIG_W) / DIG_W;
    localparam int ND_RR  = (RRW + DIG_W) / DIG_W;
    localparam int NDMAX  = (ND_C > ND_RR) ? ND_C : ND_RR;
    localparam int BW     = NDMAX * DIG_W;
    localparam int DIGC_W = $clog2(NDMAX);
    localparam int SH_W   = $clog2(BW);
    localparam int PW     = AW + DIG_W + 1;

    // Term sequence
    localparam int NTERM  = 17;
    localparam int TERM_W = $clog2(NTERM);
    localparam logic [TERM_W-1:0] TERM_LAST = TERM_W'(NTERM - 1);

    // Work queue
    localparam int QDEPTH = 4;
    localparam int QA_W   = $clog2(QDEPTH);
    localparam int QC_W   = $clog2(QDEPTH + 1);

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = (COORD_W > RAD_W) ? COORD_W : RAD_W;
    localparam logic [RAD_W-1:0]   RADIUS_RST = RAD_W'(164);
    localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_X,
        REG_START_Y,
        REG_START_Z,
        REG_END_X,
        REG_END_Y,
        REG_END_Z,
        REG_RADIUS
    } t_reg_idx;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
        logic                      last_point;
    } t_in;

    typedef struct packed {
        logic               inside_res;
        logic [COUNT_W-1:0] running_count;
        logic               count_final;
    } t_out;

    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] start_z;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic signed [COORD_W-1:0] end_z;
        logic [RAD_W-1:0]          radius;
    } t_seg;

    // Point relative to both segment ends, as queued for the back end
    typedef struct packed {
        logic signed [DW-1:0] d_x;
        logic signed [DW-1:0] d_y;
        logic signed [DW-1:0] d_z;
        logic signed [DW-1:0] f_x;
        logic signed [DW-1:0] f_y;
        logic signed [DW-1:0] f_z;
        logic                 last_point;
    } t_work;

    typedef enum logic [3:0] {
        OPD_D0, OPD_D1, OPD_D2,
        OPD_F0, OPD_F1, OPD_F2,
        OPD_L0, OPD_L1, OPD_L2,
        OPD_C0, OPD_C1, OPD_C2,
        OPD_LEN2, OPD_RAD, OPD_RR, OPD_ZERO
    } t_opnd;

    typedef enum logic [3:0] {
        DST_NONE, DST_RR, DST_C0, DST_C1, DST_C2,
        DST_CROSS, DST_LEN2, DST_DP, DST_FINAL
    } t_dst;

    typedef struct packed {
        t_opnd a_sel;
        t_opnd b_sel;
        logic  neg;
        logic  first;
        t_dst  dst;
    } t_term;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FLUSH,
        ST_DECIDE
    } t_state;

    function automatic logic signed [DW-1:0] coord_diff(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        return DW'(a) - DW'(b);
    endfunction

    // Multiply-accumulate program for one point
    function automatic t_term term_rom(input logic [TERM_W-1:0] idx);
        t_term t;
        unique case (idx)
            TERM_W'(0):  t = '{OPD_RAD,  OPD_RAD, 1'b0, 1'b1, DST_RR};
            TERM_W'(1):  t = '{OPD_D1,   OPD_F2,  1'b0, 1'b1, DST_NONE};
            TERM_W'(2):  t = '{OPD_D2,   OPD_F1,  1'b1, 1'b0, DST_C0};
            TERM_W'(3):  t = '{OPD_D2,   OPD_F0,  1'b0, 1'b1, DST_NONE};
            TERM_W'(4):  t = '{OPD_D0,   OPD_F2,  1'b1, 1'b0, DST_C1};
            TERM_W'(5):  t = '{OPD_D0,   OPD_F1,  1'b0, 1'b1, DST_NONE};
            TERM_W'(6):  t = '{OPD_D1,   OPD_F0,  1'b1, 1'b0, DST_C2};
            TERM_W'(7):  t = '{OPD_C0,   OPD_C0,  1'b0, 1'b1, DST_NONE};
            TERM_W'(8):  t = '{OPD_C1,   OPD_C1,  1'b0, 1'b0, DST_NONE};
            TERM_W'(9):  t = '{OPD_C2,   OPD_C2,  1'b0, 1'b0, DST_CROSS};
            TERM_W'(10): t = '{OPD_L0,   OPD_L0,  1'b0, 1'b1, DST_NONE};
            TERM_W'(11): t = '{OPD_L1,   OPD_L1,  1'b0, 1'b0, DST_NONE};
            TERM_W'(12): t = '{OPD_L2,   OPD_L2,  1'b0, 1'b0, DST_LEN2};
            TERM_W'(13): t = '{OPD_D0,   OPD_L0,  1'b0, 1'b1, DST_NONE};
            TERM_W'(14): t = '{OPD_D1,   OPD_L1,  1'b0, 1'b0, DST_NONE};
            TERM_W'(15): t = '{OPD_D2,   OPD_L2,  1'b0, 1'b0, DST_DP};
            TERM_W'(16): t = '{OPD_LEN2, OPD_RR,  1'b0, 1'b1, DST_FINAL};
            default:     t = '{OPD_ZERO, OPD_ZERO, 1'b0, 1'b1, DST_NONE};
        endcase
        return t;
    endfunction

    // Index of the last (signed) digit for a given B operand
    function automatic logic [DIGC_W-1:0] last_digit(input t_opnd b);
        logic [DIGC_W-1:0] n;
        unique case (b)
            OPD_D0, OPD_D1, OPD_D2,
            OPD_F0, OPD_F1, OPD_F2,
            OPD_L0, OPD_L1, OPD_L2: n = DIGC_W'(ND_D - 1);
            OPD_C0, OPD_C1, OPD_C2: n = DIGC_W'(ND_C - 1);
            OPD_RAD:                n = DIGC_W'(ND_RAD - 1);
            OPD_RR:                 n = DIGC_W'(ND_RR - 1);
            default:                n = '0;
        endcase
        return n;
    endfunction

endpackage

[src/pic_cfg.sv]
module pic_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [pic_pkg::CFG_IDX_W-1:0]      i_index,
    input  logic [pic_pkg::CFG_DATA_W-1:0]     i_data,
    output pic_pkg::t_seg                      o_seg
);

    localparam pic_pkg::t_seg SEG_RST = '{
        start_x: '0, start_y: '0, start_z: '0,
        end_x:   '0, end_y:   '0, end_z:   '0,
        radius:  pic_pkg::RADIUS_RST
    };

    pic_pkg::t_seg r_seg;
    pic_pkg::t_seg n_seg;

    assign o_ready = 1'b1;
    assign o_seg   = r_seg;

    always_comb begin
        n_seg = r_seg;
        if (i_valid) begin
            unique case (pic_pkg::t_reg_idx'(i_index))
                pic_pkg::REG_START_X: n_seg.start_x = i_data[pic_pkg::COORD_W-1:0];
                pic_pkg::REG_START_Y: n_seg.start_y = i_data[pic_pkg::COORD_W-1:0];
                pic_pkg::REG_START_Z: n_seg.start_z = i_data[pic_pkg::COORD_W-1:0];
                pic_pkg::REG_END_X:   n_seg.end_x   = i_data[pic_pkg::COORD_W-1:0];
                pic_pkg::REG_END_Y:   n_seg.end_y   = i_data[pic_pkg::COORD_W-1:0];
                pic_pkg::REG_END_Z:   n_seg.end_z   = i_data[pic_pkg::COORD_W-1:0];
                pic_pkg::REG_RADIUS:  n_seg.radius  = i_data[pic_pkg::RAD_W-1:0];
                default:              n_seg = r_seg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg <= SEG_RST;
        end else begin
            r_seg <= n_seg;
        end
    end

endmodule

[src/pic_front.sv]
module pic_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_full,
    input  pic_pkg::t_in   i_point,
    input  pic_pkg::t_seg  i_seg,
    output logic           o_q_push,
    output pic_pkg::t_work o_q_data,
    input  logic           i_q_full
);

    logic           r_valid;
    logic           n_valid;
    pic_pkg::t_work r_work;
    pic_pkg::t_work n_work;
    logic           accept;

    assign o_full   = r_valid & i_q_full;
    assign o_q_push = r_valid & ~i_q_full;
    assign o_q_data = r_work;
    assign accept   = i_push & ~o_full;

    // Refer the point to both segment ends
    always_comb begin
        n_work.d_x        = pic_pkg::coord_diff(i_point.point_x, i_seg.start_x);
        n_work.d_y        = pic_pkg::coord_diff(i_point.point_y, i_seg.start_y);
        n_work.d_z        = pic_pkg::coord_diff(i_point.point_z, i_seg.start_z);
        n_work.f_x        = pic_pkg::coord_diff(i_point.point_x, i_seg.end_x);
        n_work.f_y        = pic_pkg::coord_diff(i_point.point_y, i_seg.end_y);
        n_work.f_z        = pic_pkg::coord_diff(i_point.point_z, i_seg.end_z);
        n_work.last_point = i_point.last_point;
    end

    always_comb begin
        if (accept) begin
            n_valid = 1'b1;
        end else if (o_q_push) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_work <= n_work;
        end
    end

endmodule

[src/pic_queue.sv]
module pic_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pic_pkg::t_work i_data,
    output logic           o_full,
    input  logic           i_pop,
    output pic_pkg::t_work o_data,
    output logic           o_empty
);

    pic_pkg::t_work              r_mem [pic_pkg::QDEPTH];
    logic [pic_pkg::QA_W-1:0]    r_wr;
    logic [pic_pkg::QA_W-1:0]    r_rd;
    logic [pic_pkg::QC_W-1:0]    r_cnt;
    logic [pic_pkg::QC_W-1:0]    n_cnt;
    logic                        do_push;
    logic                        do_pop;

    assign o_full  = (r_cnt == pic_pkg::QC_W'(pic_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;
    assign o_data  = r_mem[r_rd];
    assign n_cnt   = r_cnt + pic_pkg::QC_W'(do_push) - pic_pkg::QC_W'(do_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

[src/pic_back.sv]
module pic_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pic_pkg::t_seg  i_seg,
    input  pic_pkg::t_work i_q_data,
    input  logic           i_q_empty,
    output logic           o_q_pop,
    output logic           o_empty,
    input  logic           i_pop,
    output pic_pkg::t_out  o_result
);

    // Sequencer
    pic_pkg::t_state                r_state;
    pic_pkg::t_state                n_state;
    logic [pic_pkg::TERM_W-1:0]     r_term;
    logic [pic_pkg::TERM_W-1:0]     n_term;
    logic [pic_pkg::DIGC_W-1:0]     r_dig;
    logic [pic_pkg::DIGC_W-1:0]     n_dig;
    pic_pkg::t_work                 r_work;
    pic_pkg::t_term                 term;
    logic [pic_pkg::DIGC_W-1:0]     ld;
    logic                           dig_last;
    logic                           issue;
    logic                           load_work;
    logic                           decide_fire;

    // Segment direction
    logic signed [pic_pkg::DW-1:0]  l_x;
    logic signed [pic_pkg::DW-1:0]  l_y;
    logic signed [pic_pkg::DW-1:0]  l_z;

    // Multiplier stage
    logic signed [pic_pkg::AW-1:0]  a_val;
    logic signed [pic_pkg::BW-1:0]  b_val;
    logic signed [pic_pkg::BW-1:0]  b_sh;
    logic [pic_pkg::SH_W-1:0]       shamt;
    logic [pic_pkg::DIG_W-1:0]      raw;
    logic signed [pic_pkg::DIG_W:0] dig;
    logic signed [pic_pkg::PW-1:0]  prod;

    logic                           r_p_valid;
    logic signed [pic_pkg::PW-1:0]  r_p_prod;
    logic [pic_pkg::SH_W-1:0]       r_p_shamt;
    logic                           r_p_neg;
    logic                           r_p_first;
    pic_pkg::t_dst                  r_p_dst;

    // Accumulate stage
    logic signed [pic_pkg::ACC_W-1:0] p_ext;
    logic signed [pic_pkg::ACC_W-1:0] p_sh;
    logic signed [pic_pkg::ACC_W-1:0] base;
    logic signed [pic_pkg::ACC_W-1:0] n_acc;
    logic signed [pic_pkg::ACC_W-1:0] r_acc;

    // Partial results
    logic [pic_pkg::RRW-1:0]         r_rr;
    logic signed [pic_pkg::CW-1:0]   r_c0;
    logic signed [pic_pkg::CW-1:0]   r_c1;
    logic signed [pic_pkg::CW-1:0]   r_c2;
    logic [pic_pkg::XW-1:0]          r_cross;
    logic signed [pic_pkg::L2W-1:0]  r_len2;
    logic signed [pic_pkg::L2W-1:0]  r_dp;
    logic [pic_pkg::RLW-1:0]         r_rrlen;

    // Decision, count, output register
    logic                            in_cyl;
    logic [pic_pkg::COUNT_W-1:0]     r_total;
    logic [pic_pkg::COUNT_W-1:0]     n_total;
    logic                            r_out_valid;
    pic_pkg::t_out                   r_out;
    logic                            out_free;

    assign l_x = pic_pkg::coord_diff(i_seg.end_x, i_seg.start_x);
    assign l_y = pic_pkg::coord_diff(i_seg.end_y, i_seg.start_y);
    assign l_z = pic_pkg::coord_diff(i_seg.end_z, i_seg.start_z);

    assign term     = pic_pkg::term_rom(r_term);
    assign ld       = pic_pkg::last_digit(term.b_sel);
    assign dig_last = (r_dig == ld);
    assign issue    = (r_state == pic_pkg::ST_RUN);
    assign out_free = ~r_out_valid | i_pop;
    assign o_empty  = ~r_out_valid;
    assign o_result = r_out;

    // Operand select
    always_comb begin
        unique case (term.a_sel)
            pic_pkg::OPD_D0:   a_val = pic_pkg::AW'(r_work.d_x);
            pic_pkg::OPD_D1:   a_val = pic_pkg::AW'(r_work.d_y);
            pic_pkg::OPD_D2:   a_val = pic_pkg::AW'(r_work.d_z);
            pic_pkg::OPD_L0:   a_val = pic_pkg::AW'(l_x);
            pic_pkg::OPD_L1:   a_val = pic_pkg::AW'(l_y);
            pic_pkg::OPD_L2:   a_val = pic_pkg::AW'(l_z);
            pic_pkg::OPD_C0:   a_val = r_c0;
            pic_pkg::OPD_C1:   a_val = r_c1;
            pic_pkg::OPD_C2:   a_val = r_c2;
            pic_pkg::OPD_LEN2: a_val = r_len2;
            pic_pkg::OPD_RAD:  a_val = pic_pkg::AW'($signed({1'b0, i_seg.radius}));
            default:           a_val = '0;
        endcase
    end

    always_comb begin
        unique case (term.b_sel)
            pic_pkg::OPD_F0:  b_val = pic_pkg::BW'(r_work.f_x);
            pic_pkg::OPD_F1:  b_val = pic_pkg::BW'(r_work.f_y);
            pic_pkg::OPD_F2:  b_val = pic_pkg::BW'(r_work.f_z);
            pic_pkg::OPD_L0:  b_val = pic_pkg::BW'(l_x);
            pic_pkg::OPD_L1:  b_val = pic_pkg::BW'(l_y);
            pic_pkg::OPD_L2:  b_val = pic_pkg::BW'(l_z);
            pic_pkg::OPD_C0:  b_val = pic_pkg::BW'(r_c0);
            pic_pkg::OPD_C1:  b_val = pic_pkg::BW'(r_c1);
            pic_pkg::OPD_C2:  b_val = pic_pkg::BW'(r_c2);
            pic_pkg::OPD_RAD: b_val = pic_pkg::BW'($signed({1'b0, i_seg.radius}));
            pic_pkg::OPD_RR:  b_val = pic_pkg::BW'($signed({1'b0, r_rr}));
            default:          b_val = '0;
        endcase
    end

    // One 16-bit digit of B per cycle; only the top digit carries the sign
    assign shamt = pic_pkg::SH_W'(r_dig) << pic_pkg::DIG_LG;
    assign b_sh  = b_val >>> shamt;
    assign raw   = b_sh[pic_pkg::DIG_W-1:0];
    assign dig   = {dig_last & raw[pic_pkg::DIG_W-1], raw};
    assign prod  = a_val * dig;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else begin
            r_p_valid <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_prod  <= prod;
        r_p_shamt <= shamt;
        r_p_neg   <= term.neg;
        r_p_first <= term.first & (r_dig == '0);
        r_p_dst   <= dig_last ? term.dst : pic_pkg::DST_NONE;
    end

    // Weight the digit product and accumulate
    assign p_ext = pic_pkg::ACC_W'(r_p_prod);
    assign p_sh  = p_ext <<< r_p_shamt;
    assign base  = r_p_first ? '0 : r_acc;
    assign n_acc = r_p_neg ? (base - p_sh) : (base + p_sh);

    always_ff @(posedge i_clk) begin
        if (r_p_valid) begin
            r_acc <= n_acc;
            unique case (r_p_dst)
                pic_pkg::DST_RR:    r_rr    <= n_acc[pic_pkg::RRW-1:0];
                pic_pkg::DST_C0:    r_c0    <= n_acc[pic_pkg::CW-1:0];
                pic_pkg::DST_C1:    r_c1    <= n_acc[pic_pkg::CW-1:0];
                pic_pkg::DST_C2:    r_c2    <= n_acc[pic_pkg::CW-1:0];
                pic_pkg::DST_CROSS: r_cross <= n_acc[pic_pkg::XW-1:0];
                pic_pkg::DST_LEN2:  r_len2  <= n_acc[pic_pkg::L2W-1:0];
                pic_pkg::DST_DP:    r_dp    <= n_acc[pic_pkg::L2W-1:0];
                pic_pkg::DST_FINAL: r_rrlen <= n_acc[pic_pkg::RLW-1:0];
                default:            ;
            endcase
        end
    end

    // Inside test and saturating count
    assign in_cyl = (r_len2 != '0)
                  && (pic_pkg::ACC_W'(r_cross) <= pic_pkg::ACC_W'(r_rrlen))
                  && !r_dp[pic_pkg::L2W-1]
                  && (r_dp <= r_len2);

    assign n_total = (in_cyl && (r_total != pic_pkg::COUNT_MAX))
                   ? r_total + pic_pkg::COUNT_W'(1) : r_total;

    always_comb begin
        n_state     = r_state;
        n_term      = r_term;
        n_dig       = r_dig;
        o_q_pop     = 1'b0;
        load_work   = 1'b0;
        decide_fire = 1'b0;
        unique case (r_state)
            pic_pkg::ST_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop   = 1'b1;
                    load_work = 1'b1;
                    n_term    = '0;
                    n_dig     = '0;
                    n_state   = pic_pkg::ST_RUN;
                end
            end
            pic_pkg::ST_RUN: begin
                if (dig_last) begin
                    n_dig = '0;
                    if (r_term == pic_pkg::TERM_LAST) begin
                        n_state = pic_pkg::ST_FLUSH;
                    end else begin
                        n_term = r_term + 1'b1;
                    end
                end else begin
                    n_dig = r_dig + 1'b1;
                end
            end
            pic_pkg::ST_FLUSH: begin
                n_state = pic_pkg::ST_DECIDE;
            end
            pic_pkg::ST_DECIDE: begin
                if (out_free) begin
                    decide_fire = 1'b1;
                    n_state     = pic_pkg::ST_IDLE;
                end
            end
            default: n_state = pic_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pic_pkg::ST_IDLE;
            r_term      <= '0;
            r_dig       <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_term  <= n_term;
            r_dig   <= n_dig;
            if (decide_fire) begin
                r_total     <= r_work.last_point ? '0 : n_total;
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_work) begin
            r_work <= i_q_data;
        end
        if (decide_fire) begin
            r_out.inside_res    <= in_cyl;
            r_out.running_count <= n_total;
            r_out.count_final   <= r_work.last_point;
        end
    end

endmodule

[src/point_in_cylinder_counter.sv]
// Point-in-cylinder counter: tests 3D points (Q16 metres) against a cylinder of
// configurable radius around the segment start..end and counts inside points.
// Points enter through a queue-style channel: drive i_point with push high; the
// point is taken on a clock edge where full is low. Results leave the same way:
// while empty is low, o_result holds the oldest result; pop takes it.
// Segment ends and radius are written on the cfg channel (index, data, valid),
// always ready, and must only change while no point is in flight.
// Path: entry register, queue, working point, digit passes, flush, decide.
// The shared 51x17 multiplier takes one point at a time and makes 41 digit
// passes per point (cross product, norms, dot product, bound).
// Up to six points buffer ahead of the multiplier (entry stage, 4-deep queue,
// working point); full rises once all are taken.
// A stalled result holds in the output register while the next point computes;
// the multiplier then waits with its finished decision until pop frees the slot.
// Reset (synchronous, active low) empties all queues, clears the running count,
// and restores the segment to the origin with the default radius.
module point_in_cylinder_counter (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  pic_pkg::t_in                   i_point,
    output logic                           empty,
    input  logic                           pop,
    output pic_pkg::t_out                  o_result,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [pic_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pic_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    pic_pkg::t_seg  seg;
    pic_pkg::t_work front_data;
    pic_pkg::t_work q_data;
    logic           front_push;
    logic           q_full;
    logic           q_empty;
    logic           q_pop;

    // Segment and radius registers
    pic_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cfg_valid),
        .o_ready (o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_seg   (seg)
    );

    // Accept each transaction and refer the point to both segment ends
    pic_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_full   (full),
        .i_point  (i_point),
        .i_seg    (seg),
        .o_q_push (front_push),
        .o_q_data (front_data),
        .i_q_full (q_full)
    );

    // Decouple the front end from the multiplier
    pic_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (front_data),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_data),
        .o_empty (q_empty)
    );

    // Run the multiply-accumulate program, decide, count, hold the result
    pic_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_seg     (seg),
        .i_q_data  (q_data),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_result  (o_result)
    );

endmodule

[src/pic_checker.sv]
`include "assert_macros.svh"

module pic_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          empty,
    input logic          pop,
    input pic_pkg::t_out o_result
);

    // High while the next result is the first of a cloud
    logic r_new_cloud;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_new_cloud <= 1'b1;
        end else if (pop && !empty) begin
            r_new_cloud <= o_result.count_final;
        end
    end

    `ASSERT_ANY(a_reset_empty, i_clk, !i_rst_n |=> empty)

    `ASSERT_RST(a_stall_hold, i_clk, i_rst_n, !empty && !pop |=> !empty && $stable(o_result))

    `ASSERT_RST(a_inside_counted, i_clk, i_rst_n, !empty && o_result.inside_res |-> o_result.running_count != '0)

    `ASSERT_RST(a_cloud_restart, i_clk, i_rst_n, !empty && r_new_cloud |-> o_result.running_count == pic_pkg::COUNT_W'(o_result.inside_res))

endmodule

bind point_in_cylinder_counter pic_checker u_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .empty    (empty),
    .pop      (pop),
    .o_result (o_result)
);
